@@ hw/rtl/acq_pkg.sv @@
// ----------------------------------------------------------------------------
// acq_pkg: shared types and constants of the collision query block
// Widths, operation codes, register indexes and the entry layouts of the
// box and sphere memories.
// ----------------------------------------------------------------------------
`default_nettype none

package acq_pkg;

	localparam int MAX_BOXES   = 64;
	localparam int MAX_SPHERES = 64;
	localparam int COORD_W     = 24;
	localparam int EXT_W       = 23;
	localparam int TAG_W       = 8;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int FUNC_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 23;
	localparam int SQ_W        = 2 * COORD_W;
	localparam int SUM_W       = 2 * COORD_W + 2;
	localparam int R2_W        = 2 * EXT_W;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_BOX    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SPHERE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY       = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_COUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_DEPTH  = 3'd4;

	localparam logic KIND_BOX    = 1'b0;
	localparam logic KIND_SPHERE = 1'b1;

	localparam logic [EXT_W-1:0] PLAYER_SIZE_RST = 23'd256;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COORD_W:0]   wcoord_t;
	typedef logic [EXT_W-1:0]   ext_t;
	typedef logic [TAG_W-1:0]   tag_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		coord_t [2:0] origin;
		ext_t   [2:0] extent;
		tag_t         tag;
	} box_ent_t;

	typedef struct packed {
		coord_t [2:0] centre;
		ext_t         radius;
		tag_t         tag;
	} sph_ent_t;

	typedef struct packed {
		logic kind;
		idx_t idx;
	} scan_id_t;

	typedef struct packed {
		logic kind;
		idx_t idx;
		tag_t tag;
	} ent_id_t;

	typedef struct packed {
		logic    hit;
		ent_id_t id;
	} hit_info_t;

	typedef struct packed {
		logic      busy;
		logic      found;
		hit_info_t rpt;
	} eval_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/acq_ifs.sv @@
// ----------------------------------------------------------------------------
// acq_ifs: channel interfaces of the collision query block
// Item input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface acq_item_if;
	logic                             valid;
	logic                             ready;
	logic [acq_pkg::FUNC_W-1:0]       func;
	logic [acq_pkg::IDX_W-1:0]        entry_index;
	logic signed [acq_pkg::COORD_W-1:0] pos_x;
	logic signed [acq_pkg::COORD_W-1:0] pos_y;
	logic signed [acq_pkg::COORD_W-1:0] pos_z;
	logic [acq_pkg::EXT_W-1:0]        extent_x;
	logic [acq_pkg::EXT_W-1:0]        extent_y;
	logic [acq_pkg::EXT_W-1:0]        extent_z;
	logic [acq_pkg::TAG_W-1:0]        tag_code;

	modport source (output valid, func, entry_index, pos_x, pos_y, pos_z,
		extent_x, extent_y, extent_z, tag_code, input ready);
	modport sink (input valid, func, entry_index, pos_x, pos_y, pos_z,
		extent_x, extent_y, extent_z, tag_code, output ready);
endinterface

interface acq_result_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic                      hit_kind;
	logic [acq_pkg::IDX_W-1:0] hit_index;
	logic [acq_pkg::TAG_W-1:0] hit_tag;

	modport source (output valid, hit, hit_kind, hit_index, hit_tag, input ready);
	modport sink (input valid, hit, hit_kind, hit_index, hit_tag, output ready);
endinterface

interface acq_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [acq_pkg::CFG_IDX_W-1:0]  index;
	logic [acq_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/acq_ram.sv @@
// ----------------------------------------------------------------------------
// acq_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module acq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/acq_eval.sv @@
// ----------------------------------------------------------------------------
// acq_eval: entry test pipeline
// Takes one box or sphere entry per cycle from the memories and decides
// whether it meets the player box: box overlap on all axes, or squared
// nearest-point distance below the squared radius.
// ----------------------------------------------------------------------------
`default_nettype none

module acq_eval (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          flush,
	input  wire logic                          v_s1,
	input  wire acq_pkg::scan_id_t             id_s1,
	input  wire acq_pkg::box_ent_t             box_rd,
	input  wire acq_pkg::sph_ent_t             sph_rd,
	input  wire acq_pkg::coord_t  [2:0]        pmin,
	input  wire acq_pkg::wcoord_t [2:0]        pmax,
	output acq_pkg::eval_stat_t                stat
);

	logic [2:0]                 axis_ov;
	acq_pkg::coord_t [2:0]      dist_c;
	acq_pkg::wcoord_t [2:0]     cen_w;
	acq_pkg::wcoord_t [2:0]     org_w;
	acq_pkg::wcoord_t [2:0]     bmax_w;
	acq_pkg::wcoord_t [2:0]     lo_w;
	acq_pkg::wcoord_t [2:0]     dd_w;

	logic v_s2, v_s3, v_s4, v_s5;
	acq_pkg::ent_id_t id_s2, id_s3, id_s4, id_s5;
	logic ov_s2, ov_s3, ov_s4, hit_s5;
	acq_pkg::coord_t [2:0]           d_s2;
	acq_pkg::ext_t                   r_s2;
	logic [2:0][acq_pkg::SQ_W-1:0]   sq_s3;
	logic [acq_pkg::R2_W-1:0]        r2_s3;
	logic [acq_pkg::SUM_W-1:0]       sum_s4;
	logic [acq_pkg::R2_W-1:0]        r2_s4;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cen_w[a]  = {sph_rd.centre[a][acq_pkg::COORD_W-1], sph_rd.centre[a]};
			org_w[a]  = {box_rd.origin[a][acq_pkg::COORD_W-1], box_rd.origin[a]};
			bmax_w[a] = org_w[a] + {2'b00, box_rd.extent[a]};
			lo_w[a]   = {pmin[a][acq_pkg::COORD_W-1], pmin[a]};
			axis_ov[a] = ($signed(pmax[a]) >= $signed(org_w[a])) &&
				($signed(lo_w[a]) <= $signed(bmax_w[a]));
			if ($signed(cen_w[a]) > $signed(pmax[a])) begin
				dd_w[a] = cen_w[a] - pmax[a];
			end else if ($signed(cen_w[a]) < $signed(lo_w[a])) begin
				dd_w[a] = lo_w[a] - cen_w[a];
			end else begin
				dd_w[a] = '0;
			end
			dist_c[a] = dd_w[a][acq_pkg::COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1 & ~flush;
			v_s3 <= v_s2 & ~flush;
			v_s4 <= v_s3 & ~flush;
			v_s5 <= v_s4 & ~flush;
		end
	end

	always_ff @(posedge clk) begin
		id_s2.kind <= id_s1.kind;
		id_s2.idx  <= id_s1.idx;
		id_s2.tag  <= (id_s1.kind == acq_pkg::KIND_SPHERE) ? sph_rd.tag : box_rd.tag;
		ov_s2      <= &axis_ov;
		d_s2       <= dist_c;
		r_s2       <= sph_rd.radius;

		id_s3 <= id_s2;
		ov_s3 <= ov_s2;
		for (int a = 0; a < 3; a++) begin
			sq_s3[a] <= acq_pkg::SQ_W'(d_s2[a]) * acq_pkg::SQ_W'(d_s2[a]);
		end
		r2_s3 <= acq_pkg::R2_W'(r_s2) * acq_pkg::R2_W'(r_s2);

		id_s4  <= id_s3;
		ov_s4  <= ov_s3;
		sum_s4 <= acq_pkg::SUM_W'(sq_s3[0]) + acq_pkg::SUM_W'(sq_s3[1])
			+ acq_pkg::SUM_W'(sq_s3[2]);
		r2_s4  <= r2_s3;

		id_s5  <= id_s4;
		hit_s5 <= (id_s4.kind == acq_pkg::KIND_SPHERE) ?
			(sum_s4 < acq_pkg::SUM_W'(r2_s4)) : ov_s4;
	end

	always_comb begin
		stat.busy    = v_s2 | v_s3 | v_s4 | v_s5;
		stat.found   = v_s5 & hit_s5;
		stat.rpt.hit = 1'b1;
		stat.rpt.id  = id_s5;
	end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_sphere_collision_query_top.sv @@
// ----------------------------------------------------------------------------
// aabb_sphere_collision_query_top: box and sphere collision query engine
// Keeps 64 boxes and 64 spheres in two RAMs and reports the first entry that
// a player box meets.
//
// Usage:
// - item carries one transaction per load or query. A load writes one entry
//   of the box or sphere RAM; a query gives the player box origin.
// - result carries exactly one transaction per item: the hit flag, the kind
//   (box or sphere), the index and the tag of the first entry hit, or zeros.
// - cfg writes the box and sphere counts and the player size; write it only
//   while no item is in progress.
// Timing:
// - A load's result goes through the response state to the output register.
// - A query reads one entry per cycle through a five-stage test pipeline,
//   boxes first, then spheres. Without a hit it ends once the last entry
//   has left the pipeline; a hit ends it early.
// - One item is processed at a time; the next item is accepted once the
//   previous result sits in the output register, even while it is stalled.
// Reset clears the counts to zero and the player size to 256 (1.0). RAM
// contents are not cleared; entries must be loaded before they are scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_sphere_collision_query_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	acq_item_if.sink    item,
	acq_result_if.source result,
	acq_cfg_if.sink     cfg
);

	acq_pkg::state_t state_q, state_d;

	acq_pkg::cnt_t             box_count_q, sphere_count_q;
	acq_pkg::ext_t [2:0]       psize_q;
	acq_pkg::cnt_t             nb, ns;
	acq_pkg::cnt_t             cnt_q;
	logic                      kind_q;
	acq_pkg::coord_t  [2:0]    pmin_q;
	acq_pkg::wcoord_t [2:0]    pmax_q;
	acq_pkg::coord_t  [2:0]    pos_in;

	logic                      item_fire;
	logic                      issue_v, issue_done, finish, res_load;
	logic                      we_box, we_sph;
	logic                      v_s1;
	acq_pkg::scan_id_t         id_s1;

	acq_pkg::box_ent_t         box_wr, box_rd;
	acq_pkg::sph_ent_t         sph_wr, sph_rd;
	acq_pkg::eval_stat_t       stat;

	acq_pkg::hit_info_t        pend_q, res_q;
	logic                      res_v_q;

	assign pos_in[0] = item.pos_x;
	assign pos_in[1] = item.pos_y;
	assign pos_in[2] = item.pos_z;

	assign nb = (box_count_q > acq_pkg::CNT_W'(acq_pkg::MAX_BOXES)) ?
		acq_pkg::CNT_W'(acq_pkg::MAX_BOXES) : box_count_q;
	assign ns = (sphere_count_q > acq_pkg::CNT_W'(acq_pkg::MAX_SPHERES)) ?
		acq_pkg::CNT_W'(acq_pkg::MAX_SPHERES) : sphere_count_q;

	assign cfg.ready = 1'b1;

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		issue_v    = 1'b0;
		issue_done = kind_q && !(cnt_q < ns);
		finish     = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			acq_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = (item.func == acq_pkg::FUNC_QUERY) ?
						acq_pkg::ST_SCAN : acq_pkg::ST_RESP;
				end
			end
			acq_pkg::ST_SCAN: begin
				finish  = stat.found || (issue_done && !v_s1 && !stat.busy);
				issue_v = !finish && (kind_q ? (cnt_q < ns) : (cnt_q < nb));
				if (finish) begin
					state_d = acq_pkg::ST_RESP;
				end
			end
			acq_pkg::ST_RESP: begin
				if (!res_v_q || result.ready) begin
					res_load = 1'b1;
					state_d  = acq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = acq_pkg::ST_IDLE;
			end
		endcase
	end

	assign item_fire = item.valid && item.ready;
	assign we_box    = item_fire && (item.func == acq_pkg::FUNC_LOAD_BOX);
	assign we_sph    = item_fire && (item.func == acq_pkg::FUNC_LOAD_SPHERE);

	always_comb begin
		box_wr.origin[0] = item.pos_x;
		box_wr.origin[1] = item.pos_y;
		box_wr.origin[2] = item.pos_z;
		box_wr.extent[0] = item.extent_x;
		box_wr.extent[1] = item.extent_y;
		box_wr.extent[2] = item.extent_z;
		box_wr.tag       = item.tag_code;
		sph_wr.centre[0] = item.pos_x;
		sph_wr.centre[1] = item.pos_y;
		sph_wr.centre[2] = item.pos_z;
		sph_wr.radius    = item.extent_x;
		sph_wr.tag       = item.tag_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= acq_pkg::ST_IDLE;
			box_count_q    <= '0;
			sphere_count_q <= '0;
			psize_q        <= {3{acq_pkg::PLAYER_SIZE_RST}};
			v_s1           <= 1'b0;
			res_v_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue_v;
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					acq_pkg::CFG_BOX_COUNT:
						box_count_q <= cfg.data[acq_pkg::CNT_W-1:0];
					acq_pkg::CFG_SPHERE_COUNT:
						sphere_count_q <= cfg.data[acq_pkg::CNT_W-1:0];
					acq_pkg::CFG_PLAYER_WIDTH:  psize_q[0] <= cfg.data;
					acq_pkg::CFG_PLAYER_HEIGHT: psize_q[1] <= cfg.data;
					acq_pkg::CFG_PLAYER_DEPTH:  psize_q[2] <= cfg.data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		id_s1.kind <= kind_q;
		id_s1.idx  <= cnt_q[acq_pkg::IDX_W-1:0];
		if (item_fire) begin
			cnt_q  <= '0;
			kind_q <= acq_pkg::KIND_BOX;
			pend_q <= '0;
			for (int a = 0; a < 3; a++) begin
				pmin_q[a] <= pos_in[a];
				pmax_q[a] <= {pos_in[a][acq_pkg::COORD_W-1], pos_in[a]}
					+ {2'b00, psize_q[a]};
			end
		end else if (state_q == acq_pkg::ST_SCAN) begin
			if (issue_v) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (kind_q == acq_pkg::KIND_BOX) begin
				kind_q <= acq_pkg::KIND_SPHERE;
				cnt_q  <= '0;
			end
			if (finish) begin
				pend_q <= stat.found ? stat.rpt : '0;
			end
		end
		if (res_load) begin
			res_q <= pend_q;
		end
	end

	acq_ram #(
		.WIDTH($bits(acq_pkg::box_ent_t)),
		.DEPTH(acq_pkg::MAX_BOXES)
	) u_box_ram (
		.clk   (clk),
		.we    (we_box),
		.waddr (item.entry_index),
		.wdata (box_wr),
		.raddr (cnt_q[acq_pkg::IDX_W-1:0]),
		.rdata (box_rd)
	);

	acq_ram #(
		.WIDTH($bits(acq_pkg::sph_ent_t)),
		.DEPTH(acq_pkg::MAX_SPHERES)
	) u_sph_ram (
		.clk   (clk),
		.we    (we_sph),
		.waddr (item.entry_index),
		.wdata (sph_wr),
		.raddr (cnt_q[acq_pkg::IDX_W-1:0]),
		.rdata (sph_rd)
	);

	acq_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (finish),
		.v_s1   (v_s1),
		.id_s1  (id_s1),
		.box_rd (box_rd),
		.sph_rd (sph_rd),
		.pmin   (pmin_q),
		.pmax   (pmax_q),
		.stat   (stat)
	);

	assign result.valid     = res_v_q;
	assign result.hit       = res_q.hit;
	assign result.hit_kind  = res_q.id.kind;
	assign result.hit_index = res_q.id.idx;
	assign result.hit_tag   = res_q.id.tag;

endmodule

`default_nettype wire
